[design/mhpq_pkg.sv]
`timescale 1ns / 1ps

package mhpq_pkg;

    // Heap geometry and data width.
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [ADDR_W-1:0]             t_addr;

    // Operation codes of an input word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Error codes of a result word.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

endpackage

[design/min_heap_priority_queue.sv]
`timescale 1ns / 1ps

// Binary min-heap priority queue. Each input word either inserts a signed value
// or removes the minimum; each produces one result word with the new minimum, its
// valid flag, the element count and an error code. The heap lives in one
// memory with one registered read port and one write port, and a single signed
// comparator serves every decision, so the block handles one word at a time.
// An insert compares the new value with its parent once per level it climbs,
// moving each larger parent down, and then writes the value into its slot. A
// remove moves the last element to the root and lets it descend; each level
// takes a left read and, when a right child exists, a right read and a child
// select, then a compare against the moved value. An error goes straight to the
// result. A finished result is held while the output register still holds one
// that was not taken. A new word is taken while a finished result still waits
// at the output register.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_opcode,
    input  t_value       i_value,
    output logic         o_valid,
    input  logic         i_ready,
    output t_value       o_min_value,
    output logic         o_min_valid,
    output logic [10:0]  o_entry_total,
    output logic [1:0]   o_error_code
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_CMP   = 4'd1;
    localparam logic [3:0] S_UP_PLACE = 4'd2;
    localparam logic [3:0] S_DN_LOAD  = 4'd3;
    localparam logic [3:0] S_DN_RDL   = 4'd4;
    localparam logic [3:0] S_DN_RDR   = 4'd5;
    localparam logic [3:0] S_DN_CMPR  = 4'd6;
    localparam logic [3:0] S_DN_CMPV  = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    // Control registers.
    logic [3:0] r_state, n_state;
    t_count     r_count, n_count;
    logic       r_out_valid, n_out_valid;

    // Datapath registers.
    t_count     r_pos, n_pos;
    t_count     r_kid, n_kid;
    t_value     r_v, n_v;
    t_value     r_child, n_child;
    t_value     r_root, n_root;
    logic [1:0] r_err, n_err;
    t_value     r_out_min, n_out_min;
    logic       r_out_mvalid, n_out_mvalid;
    t_count     r_out_total, n_out_total;
    logic [1:0] r_out_err, n_out_err;

    // Heap memory and its ports.
    t_value     heap_mem [CAPACITY];
    t_value     r_rdata;
    t_addr      rd_addr;
    logic       mem_we;
    t_addr      mem_waddr;
    t_value     mem_wdata;

    // Shared comparator.
    t_value     cmp_a, cmp_b;
    logic       cmp_lt;

    // Helper values.
    logic [CNT_W:0] kid_ext;
    logic           accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign cmp_lt  = (cmp_a < cmp_b);
    assign kid_ext = {r_pos, 1'b0};

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_pos        = r_pos;
        n_kid        = r_kid;
        n_v          = r_v;
        n_child      = r_child;
        n_root       = r_root;
        n_err        = r_err;
        n_out_min    = r_out_min;
        n_out_mvalid = r_out_mvalid;
        n_out_total  = r_out_total;
        n_out_err    = r_out_err;
        rd_addr      = '0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = r_v;
        cmp_a        = r_v;
        cmp_b        = r_child;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_err = ERR_NONE;
                    if (i_opcode == OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_err   = ERR_EMPTY;
                            n_state = S_FINISH;
                        end else begin
                            // Fetch the last element; it moves to the root.
                            n_count = r_count - 1'b1;
                            rd_addr = ADDR_W'(r_count - 1'b1);
                            n_state = S_DN_LOAD;
                        end
                    end else begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_err   = ERR_FULL;
                            n_state = S_FINISH;
                        end else begin
                            n_v     = i_value;
                            n_count = r_count + 1'b1;
                            n_pos   = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_state = S_UP_PLACE;
                            end else begin
                                // Fetch the parent of the new slot.
                                rd_addr = ADDR_W'(((r_count + 1'b1) >> 1) - 1'b1);
                                n_state = S_UP_CMP;
                            end
                        end
                    end
                end
            end
            S_UP_CMP: begin
                // Parent is in r_rdata; move it down if the new value is smaller.
                cmp_a = r_v;
                cmp_b = r_rdata;
                if (cmp_lt) begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_pos - 1'b1);
                    mem_wdata = r_rdata;
                    n_pos     = r_pos >> 1;
                    if ((r_pos >> 1) > CNT_W'(1)) begin
                        rd_addr = ADDR_W'((r_pos >> 2) - 1'b1);
                    end else begin
                        n_state = S_UP_PLACE;
                    end
                end else begin
                    n_state = S_UP_PLACE;
                end
            end
            S_UP_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_pos - 1'b1);
                mem_wdata = r_v;
                if (r_pos == CNT_W'(1)) begin
                    n_root = r_v;
                end
                n_state = S_FINISH;
            end
            S_DN_LOAD: begin
                n_v     = r_rdata;
                n_pos   = CNT_W'(1);
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (kid_ext > {1'b0, r_count}) begin
                    // No children left: the moved value settles here.
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(r_pos - 1'b1);
                    mem_wdata = r_v;
                    if (r_pos == CNT_W'(1)) begin
                        n_root = r_v;
                    end
                    n_state = S_FINISH;
                end else begin
                    rd_addr = ADDR_W'(kid_ext - 1'b1);
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_child = r_rdata;
                n_kid   = CNT_W'(kid_ext);
                if ((kid_ext + 1'b1) <= {1'b0, r_count}) begin
                    rd_addr = ADDR_W'(kid_ext);
                    n_state = S_DN_CMPR;
                end else begin
                    n_state = S_DN_CMPV;
                end
            end
            S_DN_CMPR: begin
                // The right child wins only if strictly smaller than the left.
                cmp_a = r_rdata;
                cmp_b = r_child;
                if (cmp_lt) begin
                    n_child = r_rdata;
                    n_kid   = r_kid + 1'b1;
                end
                n_state = S_DN_CMPV;
            end
            S_DN_CMPV: begin
                cmp_a     = r_v;
                cmp_b     = r_child;
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_pos - 1'b1);
                if (cmp_lt) begin
                    mem_wdata = r_v;
                    if (r_pos == CNT_W'(1)) begin
                        n_root = r_v;
                    end
                    n_state = S_FINISH;
                end else begin
                    mem_wdata = r_child;
                    if (r_pos == CNT_W'(1)) begin
                        n_root = r_child;
                    end
                    n_pos   = r_kid;
                    n_state = S_DN_RDL;
                end
            end
            S_FINISH: begin
                // Load the result once the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_min    = (r_count != '0) ? r_root : '0;
                    n_out_mvalid = (r_count != '0);
                    n_out_total  = r_count;
                    n_out_err    = r_err;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_kid        <= n_kid;
        r_v          <= n_v;
        r_child      <= n_child;
        r_root       <= n_root;
        r_err        <= n_err;
        r_out_min    <= n_out_min;
        r_out_mvalid <= n_out_mvalid;
        r_out_total  <= n_out_total;
        r_out_err    <= n_out_err;
    end

    // Heap memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= heap_mem[rd_addr];
    end

    assign o_valid       = r_out_valid;
    assign o_min_value   = r_out_min;
    assign o_min_valid   = r_out_mvalid;
    assign o_entry_total = 11'(r_out_total);
    assign o_error_code  = r_out_err;

`ifndef ASSERT_OFF
    // The element count never exceeds the heap capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    // The minimum is flagged valid exactly when the heap is not empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_valid == (o_entry_total != 11'd0)))
        else $error("min valid flag disagrees with entry total");

    // A remove on an empty heap can only report an empty heap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code == ERR_EMPTY)) |-> (o_entry_total == 11'd0))
        else $error("empty error with nonzero entry total");

    // An accepted word takes the sequencer out of idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after accepting a word");
`endif

endmodule
